### rtl/dmc_pkg.sv
`timescale 1ns / 1ps

package dmc_pkg;

	localparam int WORD_W     = 32;
	localparam int LINES      = 4;
	localparam int WORDS      = 4;
	localparam int LINE_IDX_W = 2;
	localparam int WORD_IDX_W = 2;
	localparam int LINE_LSB   = 4;
	localparam int WORD_LSB   = 2;
	localparam int TAG_LSB    = 6;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_STORE = 1'b1
	} opcode_t;

	typedef logic [WORDS-1:0][WORD_W-1:0] line_data_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic lookup;
		logic fill;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic hit;
		logic clear_last;
		logic out_free;
	} dp_status_t;

endpackage

### rtl/dmc_store.sv
`timescale 1ns / 1ps

module dmc_store #(
	parameter int ROW_W = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [ROW_W-1:0]         wr_row,
	input  dmc_pkg::line_data_t      wr_data,
	input  logic                     rd_en,
	input  logic [ROW_W-1:0]         rd_row,
	output dmc_pkg::line_data_t      rd_data
);
	import dmc_pkg::*;

	localparam longint DEPTH = 64'd1 << ROW_W;

	line_data_t mem_q [DEPTH];
	line_data_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_row] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_row];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/dmc_ctrl.sv
`timescale 1ns / 1ps

module dmc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dmc_pkg::dp_status_t status,
	output dmc_pkg::ctrl_cmd_t  cmd
);
	import dmc_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_LOOKUP = 5'b00100,
		ST_FILL   = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = status.hit ? ST_DONE : ST_FILL;
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/dmc_datapath.sv
`timescale 1ns / 1ps

module dmc_datapath #(
	parameter int ADDR_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dmc_pkg::ctrl_cmd_t          cmd,
	output dmc_pkg::dp_status_t         status,
	input  logic                        opcode,
	input  logic [ADDR_BITS-1:0]        address,
	input  logic [dmc_pkg::WORD_W-1:0]  store_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dmc_pkg::WORD_W-1:0]  read_data,
	output logic                        hit,
	output logic                        wrote_back,
	output logic [dmc_pkg::WORD_W-1:0]  hit_total,
	output logic [dmc_pkg::WORD_W-1:0]  miss_total
);
	import dmc_pkg::*;

	localparam int TAG_W = ADDR_BITS - TAG_LSB;
	localparam int ROW_W = ADDR_BITS - LINE_LSB;

	logic                  req_op_q;
	logic [ADDR_BITS-1:0]  req_addr_q;
	logic [WORD_W-1:0]     req_data_q;

	logic [LINES-1:0]      valid_q;
	logic [LINES-1:0]      dirty_q;
	logic [TAG_W-1:0]      tag_q [LINES];
	line_data_t            words_q [LINES];

	logic [ROW_W-1:0]      clr_q;
	logic                  hit_q;
	logic                  wb_q;
	logic [WORD_W-1:0]     hit_cnt_q;
	logic [WORD_W-1:0]     miss_cnt_q;

	logic                  out_valid_q;
	logic [WORD_W-1:0]     read_data_q;
	logic                  hit_out_q;
	logic                  wb_out_q;
	logic [WORD_W-1:0]     hit_total_q;
	logic [WORD_W-1:0]     miss_total_q;

	logic [LINE_IDX_W-1:0] line_idx;
	logic [WORD_IDX_W-1:0] word_idx;
	logic [TAG_W-1:0]      req_tag;
	logic [ROW_W-1:0]      req_row;
	logic                  hit_now;
	logic                  victim_dirty;
	logic                  wb_now;
	logic                  mem_wr_en;
	logic [ROW_W-1:0]      mem_wr_row;
	line_data_t            mem_wr_data;
	line_data_t            mem_rd_data;
	logic [WORD_W-1:0]     hit_cnt_next;
	logic [WORD_W-1:0]     miss_cnt_next;

	assign line_idx     = req_addr_q[LINE_LSB +: LINE_IDX_W];
	assign word_idx     = req_addr_q[WORD_LSB +: WORD_IDX_W];
	assign req_tag      = req_addr_q[ADDR_BITS-1:TAG_LSB];
	assign req_row      = req_addr_q[ADDR_BITS-1:LINE_LSB];
	assign hit_now      = valid_q[line_idx] && (tag_q[line_idx] == req_tag);
	assign victim_dirty = valid_q[line_idx] && dirty_q[line_idx];
	assign wb_now       = !hit_now && victim_dirty;

	assign status.hit        = hit_now;
	assign status.clear_last = &clr_q;
	assign status.out_free   = !out_valid_q || out_ready;

	always_comb begin
		if (cmd.clear) begin
			mem_wr_en   = 1'b1;
			mem_wr_row  = clr_q;
			mem_wr_data = '0;
		end else begin
			mem_wr_en   = cmd.lookup && wb_now;
			mem_wr_row  = {tag_q[line_idx], line_idx};
			mem_wr_data = words_q[line_idx];
		end
	end

	dmc_store #(
		.ROW_W(ROW_W)
	) u_store (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_row (mem_wr_row),
		.wr_data(mem_wr_data),
		.rd_en  (cmd.lookup),
		.rd_row (req_row),
		.rd_data(mem_rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_op_q   <= opcode;
			req_addr_q <= address;
			req_data_q <= store_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + ROW_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
		end else if (cmd.fill) begin
			valid_q[line_idx] <= 1'b1;
			dirty_q[line_idx] <= 1'b0;
		end else if (cmd.finish && (req_op_q == OP_STORE)) begin
			dirty_q[line_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill) begin
			tag_q[line_idx]   <= req_tag;
			words_q[line_idx] <= mem_rd_data;
		end else if (cmd.finish && (req_op_q == OP_STORE)) begin
			words_q[line_idx][word_idx] <= req_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_q <= hit_now;
			wb_q  <= wb_now;
		end
	end

	assign hit_cnt_next  = hit_q ? hit_cnt_q + WORD_W'(1) : hit_cnt_q;
	assign miss_cnt_next = hit_q ? miss_cnt_q : miss_cnt_q + WORD_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else if (cmd.finish) begin
			hit_cnt_q  <= hit_cnt_next;
			miss_cnt_q <= miss_cnt_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			read_data_q  <= (req_op_q == OP_STORE) ? '0 : words_q[line_idx][word_idx];
			hit_out_q    <= hit_q;
			wb_out_q     <= wb_q;
			hit_total_q  <= hit_cnt_next;
			miss_total_q <= miss_cnt_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign hit        = hit_out_q;
	assign wrote_back = wb_out_q;
	assign hit_total  = hit_total_q;
	assign miss_total = miss_total_q;

endmodule

### rtl/direct_mapped_writeback_cache.sv
`timescale 1ns / 1ps

// Direct-mapped, write-back, write-allocate cache of four 16-byte lines in front of a
// backing store of 2**(ADDR_BITS-4) line-wide rows. After reset the block clears the
// backing store one row per cycle, with in_ready low. Each request is then handled
// alone, through the controller's lookup and respond steps on a hit, with a fill step
// between them on a miss that takes the line from the registered read of the backing
// store; the respond step waits until the output register is free. A dirty victim is
// written back in the lookup cycle through the store's separate write port. The
// result sits in an output register, so a new request is accepted while it waits.
module direct_mapped_writeback_cache #(
	parameter int ADDR_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        opcode,
	input  logic [ADDR_BITS-1:0]        address,
	input  logic [dmc_pkg::WORD_W-1:0]  store_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dmc_pkg::WORD_W-1:0]  read_data,
	output logic                        hit,
	output logic                        wrote_back,
	output logic [dmc_pkg::WORD_W-1:0]  hit_total,
	output logic [dmc_pkg::WORD_W-1:0]  miss_total
);
	import dmc_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	dmc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	dmc_datapath #(
		.ADDR_BITS(ADDR_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.opcode    (opcode),
		.address   (address),
		.store_data(store_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_data (read_data),
		.hit       (hit),
		.wrote_back(wrote_back),
		.hit_total (hit_total),
		.miss_total(miss_total)
	);

endmodule

### tb/cache_checker.sv
`timescale 1ns / 1ps

module cache_checker #(
	parameter int ADDR_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        opcode,
	input  logic [ADDR_BITS-1:0]        address,
	input  logic [dmc_pkg::WORD_W-1:0]  store_data,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [dmc_pkg::WORD_W-1:0]  read_data,
	input  logic                        hit,
	input  logic                        wrote_back,
	input  logic [dmc_pkg::WORD_W-1:0]  hit_total,
	input  logic [dmc_pkg::WORD_W-1:0]  miss_total,
	output int                          mismatches,
	output int                          results_due
);
	import dmc_pkg::*;

	localparam int TAG_W = ADDR_BITS - TAG_LSB;
	localparam int STORE_WORDS = 2 ** (ADDR_BITS - WORD_LSB);

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic              hit;
		logic              wrote_back;
		logic [WORD_W-1:0] hit_total;
		logic [WORD_W-1:0] miss_total;
	} access_result_t;

	logic              line_valid [LINES];
	logic              line_dirty [LINES];
	logic [TAG_W-1:0]  line_tag [LINES];
	logic [WORD_W-1:0] line_words [LINES][WORDS];
	logic [WORD_W-1:0] memory_words [STORE_WORDS];
	logic [WORD_W-1:0] hit_count;
	logic [WORD_W-1:0] miss_count;

	access_result_t awaited_results [$];
	access_result_t predicted;
	access_result_t oldest;

	task automatic clear_cache_state();
		for (int i = 0; i < LINES; i++) begin
			line_valid[i] = 1'b0;
			line_dirty[i] = 1'b0;
			line_tag[i] = '0;
			for (int w = 0; w < WORDS; w++)
				line_words[i][w] = '0;
		end
		for (int i = 0; i < STORE_WORDS; i++)
			memory_words[i] = '0;
		hit_count = '0;
		miss_count = '0;
		awaited_results.delete();
		mismatches = 0;
		results_due = 0;
	endtask

	task automatic cache_access(input opcode_t op, input logic [ADDR_BITS-1:0] addr,
			input logic [WORD_W-1:0] wdata, output access_result_t res);
		logic [LINE_IDX_W-1:0] line_idx;
		logic [WORD_IDX_W-1:0] word_idx;
		logic [TAG_W-1:0]      tag_bits;
		line_idx = addr[LINE_LSB +: LINE_IDX_W];
		word_idx = addr[WORD_LSB +: WORD_IDX_W];
		tag_bits = addr[ADDR_BITS-1:TAG_LSB];
		res = '0;
		res.hit = line_valid[line_idx] && (line_tag[line_idx] == tag_bits);
		if (res.hit) begin
			hit_count++;
		end else begin
			miss_count++;
			if (line_valid[line_idx] && line_dirty[line_idx]) begin
				for (int w = 0; w < WORDS; w++)
					memory_words[{line_tag[line_idx], line_idx, WORD_IDX_W'(w)}] =
						line_words[line_idx][w];
				res.wrote_back = 1'b1;
			end
			for (int w = 0; w < WORDS; w++)
				line_words[line_idx][w] = memory_words[{tag_bits, line_idx, WORD_IDX_W'(w)}];
			line_tag[line_idx] = tag_bits;
			line_valid[line_idx] = 1'b1;
			line_dirty[line_idx] = 1'b0;
		end
		if (op == OP_STORE) begin
			line_words[line_idx][word_idx] = wdata;
			line_dirty[line_idx] = 1'b1;
		end else begin
			res.read_data = line_words[line_idx][word_idx];
		end
		res.hit_total = hit_count;
		res.miss_total = miss_count;
	endtask

	task automatic check_field(input string field, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_cache_state();
		end else begin
			if (in_valid && in_ready) begin
				cache_access(opcode_t'(opcode), address, store_data, predicted);
				awaited_results.push_back(predicted);
			end
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with no request pending, actual read_data %h",
						$time, read_data);
				end else begin
					oldest = awaited_results.pop_front();
					check_field("read_data", oldest.read_data, read_data);
					check_field("hit", WORD_W'(oldest.hit), WORD_W'(hit));
					check_field("wrote_back", WORD_W'(oldest.wrote_back), WORD_W'(wrote_back));
					check_field("hit_total", oldest.hit_total, hit_total);
					check_field("miss_total", oldest.miss_total, miss_total);
				end
			end
			results_due = awaited_results.size();
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import dmc_pkg::*;

	localparam int ADDR_BITS = 12;
	localparam int TAG_W = ADDR_BITS - TAG_LSB;
	localparam int CYCLE_LIMIT = 200000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 opcode;
	logic [ADDR_BITS-1:0] address;
	logic [WORD_W-1:0]    store_data;
	logic                 out_valid;
	logic                 out_ready;
	logic [WORD_W-1:0]    read_data;
	logic                 hit;
	logic                 wrote_back;
	logic [WORD_W-1:0]    hit_total;
	logic [WORD_W-1:0]    miss_total;

	int mismatches;
	int results_due;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycle_count = 0;
	logic [TAG_W-1:0] hot_tags [3];

	direct_mapped_writeback_cache #(
		.ADDR_BITS(ADDR_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.address(address),
		.store_data(store_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.hit(hit),
		.wrote_back(wrote_back),
		.hit_total(hit_total),
		.miss_total(miss_total)
	);

	cache_checker #(
		.ADDR_BITS(ADDR_BITS)
	) checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.address(address),
		.store_data(store_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.hit(hit),
		.wrote_back(wrote_back),
		.hit_total(hit_total),
		.miss_total(miss_total),
		.mismatches(mismatches),
		.results_due(results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	task automatic send_request(input opcode_t op, input logic [ADDR_BITS-1:0] addr,
			input logic [WORD_W-1:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		address <= addr;
		store_data <= data;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_request();
		logic [ADDR_BITS-1:0] addr;
		logic [WORD_W-1:0]    data;
		addr = ADDR_BITS'($urandom);
		// Most requests stay on a few tags so that hits, conflicts and dirty evictions all occur.
		if ($urandom_range(99) < 75)
			addr[ADDR_BITS-1:TAG_LSB] = hot_tags[$urandom_range(2)];
		case ($urandom_range(9))
			0: data = '0;
			1: data = '1;
			default: data = $urandom;
		endcase
		send_request(opcode_t'($urandom_range(1)), addr, data);
	endtask

	task automatic wait_until_answered();
		in_valid <= 1'b0;
		while (results_due != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int sender_pct, input int receiver_pct, input int count);
		wait_until_answered();
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		foreach (hot_tags[i])
			hot_tags[i] = TAG_W'($urandom);
		repeat (count)
			send_random_request();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_LOAD;
		address = '0;
		store_data = '0;
		out_ready = 1'b0;
		send_idle_pct = 34;
		recv_idle_pct = 58;
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request(OP_LOAD, 12'h000, 32'h1234_5678);
		send_request(OP_STORE, 12'h004, 32'hffff_ffff);
		send_request(OP_LOAD, 12'h004, 32'h0);
		send_request(OP_LOAD, 12'h007, 32'h0);
		send_request(OP_STORE, 12'hfff, 32'h0000_0000);
		send_request(OP_STORE, 12'hff0, 32'ha5a5_a5a5);
		send_request(OP_LOAD, 12'h030, 32'h0);
		send_request(OP_LOAD, 12'hffe, 32'h0);
		send_request(OP_LOAD, 12'hff1, 32'h0);
		send_request(OP_STORE, 12'h040, 32'h5a5a_5a5a);
		send_request(OP_LOAD, 12'h005, 32'h0);
		send_request(OP_LOAD, 12'h040, 32'h0);
		send_request(OP_LOAD, 12'h010, 32'h0);
		send_request(OP_STORE, 12'h02b, 32'h8000_0001);
		send_request(OP_STORE, 12'h800, 32'h8000_0000);
		send_request(OP_LOAD, 12'h02a, 32'h0);
		send_request(OP_STORE, 12'ha94, 32'h0000_0001);
		send_request(OP_LOAD, 12'h55c, 32'h0);
		send_request(OP_LOAD, 12'h800, 32'h0);
		send_request(OP_LOAD, 12'ha94, 32'h0);

		run_phase(34, 58, 450);
		run_phase(58, 34, 450);
		run_phase(0, 0, 350);

		wait_until_answered();
		repeat (20)
			@(negedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/dmc_pkg.sv
rtl/dmc_store.sv
rtl/dmc_ctrl.sv
rtl/dmc_datapath.sv
rtl/direct_mapped_writeback_cache.sv
tb/cache_checker.sv
tb/tb_top.sv
